@@ rtl/core/dcu_pkg.sv @@
// ============================================================================
// Dispersive cell update package
// Widths, shared types and constants for the per-cell IIR update pipeline.
// ============================================================================
package dcu_pkg;

  // Grid and sample geometry.
  localparam int unsigned CELLS    = 4096;
  localparam int unsigned CELL_W   = $clog2(CELLS);
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned ORD_W    = 2;

  // Past samples kept per cell: two past D/B values, one E/H value two steps back.
  localparam int unsigned DB_SLOTS = 2;
  localparam int unsigned EH_SLOTS = 1;

  // Product terms: b0*db, b1*db1, b2*db2, a1*eh1, a2*eh2.
  localparam int unsigned NTERMS   = 5;
  localparam int unsigned TERM_B0  = 0;
  localparam int unsigned TERM_B1  = 1;
  localparam int unsigned TERM_B2  = 2;
  localparam int unsigned TERM_A1  = 3;
  localparam int unsigned TERM_A2  = 4;

  // Fixed-point rounding and clipping.
  localparam int unsigned PROD_W   = 2 * WORD_W;
  localparam int unsigned FRAC_SH  = 24;
  localparam logic [PROD_W:0] HALF_LSB = (PROD_W + 1)'(1) << (FRAC_SH - 1);
  localparam logic [WORD_W-1:0] SAT_MAX = {1'b0, {(WORD_W - 1){1'b1}}};
  localparam logic [WORD_W-1:0] SAT_MIN = {1'b1, {(WORD_W - 1){1'b0}}};

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W    = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER_DB = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER_EH = 1'b1;

  // Operand bundle handed from the history stage to the multiply pipeline.
  typedef struct packed {
    logic [NTERMS-1:0][WORD_W-1:0] samp;
    logic [NTERMS-1:0][WORD_W-1:0] coef;
  } ops_t;

endpackage

@@ rtl/core/dispersive_cell_iir_update_top.sv @@
// ============================================================================
// Dispersive cell IIR update
// Per-cell direct-form-I update of a dispersive material's E or H value.
// ============================================================================
// Usage:
//   Input channel (in_valid_i / in_stall_o): one request per grid cell, with
//   its present D/B sample, its previous E/H sample and five coefficients.
//   Output channel (out_valid_o / out_stall_i): one result per request, in
//   request order, with the Q16.16 value and a saturation flag.
//   Configuration channel (cfg_valid_i / cfg_ready_o): index 0 writes the
//   numerator order, index 1 the denominator order; write only while idle.
// An accepted request passes the history and multiply stages to its result;
// one request is taken per cycle while in_stall_o is low. The history RAM
// read and write-back form a per-cell loop, so back-to-back requests on the
// same cell are forwarded. After reset both history RAMs are cleared one cell
// per cycle, during which in_stall_o is high; configuration writes are taken
// throughout. When the receiver stalls, the pipeline fills its empty stages
// and then stalls the input; no request is lost or repeated.
// ============================================================================
module dispersive_cell_iir_update_top
  import dcu_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Input requests
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [CELL_W-1:0]        cell_index_i,
  input  logic signed [WORD_W-1:0] db_now_i,
  input  logic signed [WORD_W-1:0] eh_prev_i,
  input  logic signed [WORD_W-1:0] coef_b0_i,
  input  logic signed [WORD_W-1:0] coef_b1_i,
  input  logic signed [WORD_W-1:0] coef_b2_i,
  input  logic signed [WORD_W-1:0] coef_a1_i,
  input  logic signed [WORD_W-1:0] coef_a2_i,
  // Results
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [WORD_W-1:0] new_eh_o,
  output logic                     saturated_o,
  // Configuration writes
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [ORD_W-1:0]         cfg_data_i
);

  logic [ORD_W-1:0]              order_db_q, order_eh_q;
  logic                          in_ready;
  logic                          ops_valid, ops_ready;
  ops_t                          ops;
  logic [NTERMS-1:0][WORD_W-1:0] coef;
  logic [WORD_W-1:0]             new_eh;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !in_ready;

  // Coefficients in term order.
  always_comb begin
    coef[TERM_B0] = coef_b0_i;
    coef[TERM_B1] = coef_b1_i;
    coef[TERM_B2] = coef_b2_i;
    coef[TERM_A1] = coef_a1_i;
    coef[TERM_A2] = coef_a2_i;
  end

  // Order registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_db_q <= '0;
      order_eh_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_ORDER_DB: order_db_q <= cfg_data_i;
        REG_ORDER_EH: order_eh_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  dcu_hist u_hist (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready),
    .cell_index_i (cell_index_i),
    .db_now_i     (db_now_i),
    .eh_prev_i    (eh_prev_i),
    .coef_i       (coef),
    .order_db_i   (order_db_q),
    .order_eh_i   (order_eh_q),
    .ops_valid_o  (ops_valid),
    .ops_ready_i  (ops_ready),
    .ops_o        (ops)
  );

  dcu_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ops_valid_i (ops_valid),
    .ops_ready_o (ops_ready),
    .ops_i       (ops),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .new_eh_o    (new_eh),
    .saturated_o (saturated_o)
  );

  assign new_eh_o = $signed(new_eh);

`ifndef SYNTHESIS
  // A clipped result carries one of the two range limits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |-> (new_eh_o == $signed(SAT_MAX)) ||
                                   (new_eh_o == $signed(SAT_MIN)))
    else $error("saturated result is not a range limit");

  // A result appearing after an empty output comes from an earlier accepted request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 5))
    else $error("result without a matching request");

  // No request gets in right after reset, when the history clearing starts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> in_stall_o)
    else $error("input open during history clearing");
`endif

endmodule

@@ rtl/core/dcu_ram.sv @@
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port with a registered, enabled read.
// ============================================================================
module dcu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read; the data holds while the read is not enabled.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/dcu_hist.sv @@
// ============================================================================
// Dispersive cell update: history stage
// Reads the per-cell history, forwards the most recent write, shifts the new
// samples in and builds the operand bundle for the multiply pipeline.
// ============================================================================
module dcu_hist
  import dcu_pkg::*;
(
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [CELL_W-1:0]              cell_index_i,
  input  logic [WORD_W-1:0]              db_now_i,
  input  logic [WORD_W-1:0]              eh_prev_i,
  input  logic [NTERMS-1:0][WORD_W-1:0]  coef_i,
  input  logic [ORD_W-1:0]               order_db_i,
  input  logic [ORD_W-1:0]               order_eh_i,
  output logic                           ops_valid_o,
  input  logic                           ops_ready_i,
  output ops_t                           ops_o
);

  localparam int unsigned DBH_W = DB_SLOTS * WORD_W;
  localparam int unsigned EHH_W = EH_SLOTS * WORD_W;

  // Clearing pass state.
  logic              clr_q;
  logic [CELL_W-1:0] clr_cnt_q;

  // Stage 1: request waiting for its history read.
  logic                          v1_q;
  logic [CELL_W-1:0]             cell1_q;
  logic [WORD_W-1:0]             db1_q;
  logic [WORD_W-1:0]             eh1_q;
  logic [NTERMS-1:0][WORD_W-1:0] coef1_q;

  // Last history write, for a back-to-back request on the same cell.
  logic              fwd_v_q;
  logic [CELL_W-1:0] fwd_cell_q;
  logic [DBH_W-1:0]  fwd_db_q;
  logic [EHH_W-1:0]  fwd_eh_q;

  // Stage 2: operand bundle.
  logic v2_q;
  ops_t ops2_q;
  ops_t ops2_d;

  logic              en1, en2, accept, adv1, hit;
  logic [DBH_W-1:0]  db_rd, db_hist, db_wdata;
  logic [EHH_W-1:0]  eh_rd, eh_hist, eh_wdata;
  logic              ram_we;
  logic [CELL_W-1:0] ram_waddr;

  // Stage enables: a stage moves when it is empty or the next one moves.
  assign en2        = !v2_q || ops_ready_i;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1 && !clr_q;
  assign accept     = in_valid_i && in_ready_o;
  assign adv1       = v1_q && en2;

  // Pick the newest history: the write that landed with our read, or the RAM.
  assign hit     = fwd_v_q && (fwd_cell_q == cell1_q);
  assign db_hist = hit ? fwd_db_q : db_rd;
  assign eh_hist = hit ? fwd_eh_q : eh_rd;

  // Shift the present samples into the history; zeros during the clearing pass.
  assign db_wdata  = clr_q ? '0 : {db_hist[WORD_W-1:0], db1_q};
  assign eh_wdata  = clr_q ? '0 : eh1_q;
  assign ram_we    = clr_q || adv1;
  assign ram_waddr = clr_q ? clr_cnt_q : cell1_q;

  dcu_ram #(
    .WIDTH (DBH_W),
    .DEPTH (CELLS)
  ) u_db_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (db_wdata),
    .re_i    (accept),
    .raddr_i (cell_index_i),
    .rdata_o (db_rd)
  );

  dcu_ram #(
    .WIDTH (EHH_W),
    .DEPTH (CELLS)
  ) u_eh_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (eh_wdata),
    .re_i    (accept),
    .raddr_i (cell_index_i),
    .rdata_o (eh_rd)
  );

  // Operand selection; a term beyond the configured order gets a zero coefficient.
  always_comb begin
    ops2_d.samp[TERM_B0] = db1_q;
    ops2_d.samp[TERM_B1] = db_hist[WORD_W-1:0];
    ops2_d.samp[TERM_B2] = db_hist[2*WORD_W-1:WORD_W];
    ops2_d.samp[TERM_A1] = eh1_q;
    ops2_d.samp[TERM_A2] = eh_hist[WORD_W-1:0];
    ops2_d.coef[TERM_B0] = coef1_q[TERM_B0];
    ops2_d.coef[TERM_B1] = (order_db_i >= ORD_W'(1)) ? coef1_q[TERM_B1] : '0;
    ops2_d.coef[TERM_B2] = (order_db_i >= ORD_W'(2)) ? coef1_q[TERM_B2] : '0;
    ops2_d.coef[TERM_A1] = (order_eh_i >= ORD_W'(1)) ? coef1_q[TERM_A1] : '0;
    ops2_d.coef[TERM_A2] = (order_eh_i >= ORD_W'(2)) ? coef1_q[TERM_A2] : '0;
  end

  // Clearing pass: one entry per cycle after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + CELL_W'(1);
      if (clr_cnt_q == CELL_W'(CELLS - 1)) begin
        clr_q <= 1'b0;
      end
    end
  end

  // Stage valid bits and forwarding valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      fwd_v_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= accept;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (adv1) begin
        fwd_v_q <= 1'b1;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cell1_q <= cell_index_i;
      db1_q   <= db_now_i;
      eh1_q   <= eh_prev_i;
      coef1_q <= coef_i;
    end
    if (adv1) begin
      ops2_q     <= ops2_d;
      fwd_cell_q <= cell1_q;
      fwd_db_q   <= db_wdata;
      fwd_eh_q   <= eh_wdata;
    end
  end

  assign ops_valid_o = v2_q;
  assign ops_o       = ops2_q;

endmodule

@@ rtl/core/dcu_mac.sv @@
// ============================================================================
// Dispersive cell update: multiply-accumulate pipeline
// Five parallel products, a two-level sum, round half up to Q16.16 and
// saturation into the output register.
// ============================================================================
module dcu_mac
  import dcu_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              ops_valid_i,
  output logic              ops_ready_o,
  input  ops_t              ops_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [WORD_W-1:0] new_eh_o,
  output logic              saturated_o
);

  localparam int unsigned SUM_W = PROD_W + 1;
  localparam int unsigned TOT_W = PROD_W + 3;
  localparam int unsigned RND_W = TOT_W - FRAC_SH;

  logic                                v3_q, v4_q, vo_q;
  logic signed [NTERMS-1:0][PROD_W-1:0] prod_q;
  logic signed [NTERMS-1:0][PROD_W-1:0] prod_d;
  logic signed [SUM_W-1:0]             sum_b_q, sum_c_q, sum_a_q;
  logic signed [SUM_W-1:0]             sum_b_d, sum_c_d, sum_a_d;
  logic [WORD_W-1:0]                   new_eh_q, new_eh_d;
  logic                                sat_q, sat_d;
  logic                                en3, en4, eno;
  logic signed [TOT_W-1:0]             total;
  logic [RND_W-1:0]                    rnd;
  logic                                clip_hi, clip_lo;

  // Stage enables.
  assign eno         = !vo_q || !out_stall_i;
  assign en4         = !v4_q || eno;
  assign en3         = !v3_q || en4;
  assign ops_ready_o = en3;

  // Products, exact Q24.40.
  always_comb begin
    for (int i = 0; i < NTERMS; i++) begin
      prod_d[i] = $signed(ops_i.samp[i]) * $signed(ops_i.coef[i]);
    end
  end

  // First sum level: numerator pair, denominator pair, last numerator term plus half LSB.
  // An element of the product array is unsigned, so it is sign-extended explicitly.
  assign sum_b_d = SUM_W'($signed(prod_q[TERM_B0])) + SUM_W'($signed(prod_q[TERM_B1]));
  assign sum_c_d = SUM_W'($signed(prod_q[TERM_B2])) + $signed(HALF_LSB);
  assign sum_a_d = SUM_W'($signed(prod_q[TERM_A1])) + SUM_W'($signed(prod_q[TERM_A2]));

  // Final sum, floor to Q16.16 and clip to the 32-bit range.
  always_comb begin
    total   = TOT_W'(sum_b_q) + TOT_W'(sum_c_q) - TOT_W'(sum_a_q);
    rnd     = total[TOT_W-1:FRAC_SH];
    clip_hi = !rnd[RND_W-1] && (rnd[RND_W-2:WORD_W-1] != '0);
    clip_lo = rnd[RND_W-1] && (rnd[RND_W-2:WORD_W-1] != '1);
    sat_d   = clip_hi || clip_lo;
    if (clip_hi) begin
      new_eh_d = SAT_MAX;
    end else if (clip_lo) begin
      new_eh_d = SAT_MIN;
    end else begin
      new_eh_d = rnd[WORD_W-1:0];
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en3) begin
        v3_q <= ops_valid_i;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
      if (eno) begin
        vo_q <= v4_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en3 && ops_valid_i) begin
      prod_q <= prod_d;
    end
    if (en4 && v3_q) begin
      sum_b_q <= sum_b_d;
      sum_c_q <= sum_c_d;
      sum_a_q <= sum_a_d;
    end
    if (eno && v4_q) begin
      new_eh_q <= new_eh_d;
      sat_q    <= sat_d;
    end
  end

  assign out_valid_o = vo_q;
  assign new_eh_o    = new_eh_q;
  assign saturated_o = sat_q;

endmodule
